// ----- rtl/cidr_am_pkg.sv -----
// ----------------------------------------------------------------------------
// cidr_am_pkg: shared types and constants of the CIDR allowlist matcher
// Table size, index widths, command and status codes, and the command/status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package cidr_am_pkg;

    localparam int MAX_RANGES = 16;
    localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam int ADDR_W = 64;
    localparam int PLEN_W = 8;

    localparam logic [PLEN_W-1:0] V4_MAX_PLEN = 8'd32;
    localparam logic [PLEN_W-1:0] V6_MAX_PLEN = 8'd128;

    // Item commands
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_PLEN = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture the input beat
        logic scan;    // read the next table entry
        logic commit;  // form the result, perform the add
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_check;  // held item is a check
        logic empty;     // table holds no range
        logic rd_last;   // entry being read is the last stored one
    } sts_t;

endpackage

// ----- rtl/cidr_allowlist_matcher_top.sv -----
// ----------------------------------------------------------------------------
// cidr_allowlist_matcher_top: IPv4/IPv6 CIDR allowlist matcher
// Stores up to MAX_RANGES network ranges and checks addresses against them.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------------------------------
//  s_      | in        | s_valid / s_ready | command, is_ipv6, address_high,
//          |           |                   | address_low, pfx_len
//  m_      | out       | m_valid / m_ready | allowed, status
//
//  An add, or a check of an empty table, steps through idle, decide and finish;
//  a check of stored ranges also scans them between decide and finish, one range
//  per cycle through the single table read port, then drains the last read.
//  Synchronous active-low reset empties the table but never clears its entries.
//  A new beat is taken while the last result waits; a stalled result holds the
//  finish of the next item until it is taken.
//
module cidr_allowlist_matcher_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_command,
    input  logic                                  s_is_ipv6,
    input  logic [cidr_am_pkg::ADDR_W-1:0]        s_address_high,
    input  logic [cidr_am_pkg::ADDR_W-1:0]        s_address_low,
    input  logic [cidr_am_pkg::PLEN_W-1:0]        s_pfx_len,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_allowed,
    output logic [1:0]                            m_status
);

    // Command and status bundles between sequencer and datapath
    cidr_am_pkg::cmd_t cmd;
    cidr_am_pkg::sts_t sts;

    // Sequencer: capture, scan, hand-off; owns m_valid
    cidr_am_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: held beat, range table, compare, result registers
    cidr_am_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_command       (s_command),
        .s_is_ipv6       (s_is_ipv6),
        .s_address_high  (s_address_high),
        .s_address_low   (s_address_low),
        .s_pfx_len       (s_pfx_len),
        .m_allowed       (m_allowed),
        .m_status        (m_status)
    );

`ifndef NO_ASSERTIONS
    // Only one item in work: an accepted beat closes the input side
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in work");

    // A result never carries an undefined status code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == cidr_am_pkg::STATUS_OK ||
                     m_status == cidr_am_pkg::STATUS_BAD_PLEN ||
                     m_status == cidr_am_pkg::STATUS_FULL))
        else $error("result status code out of range");

    // Allowed is only ever reported with ok status
    a_allowed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_allowed) |-> (m_status == cidr_am_pkg::STATUS_OK))
        else $error("allowed result with error status");

    // No two control actions of the sequencer in one cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.scan, cmd.commit}))
        else $error("conflicting datapath commands");
`endif

endmodule

// ----- rtl/cidr_am_ctrl.sv -----
// ----------------------------------------------------------------------------
// cidr_am_ctrl: sequencing controller
// Steps each item through capture, table scan and result hand-off, and owns
// the result valid flag.
// ----------------------------------------------------------------------------
module cidr_am_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  cidr_am_pkg::sts_t  sts,
    output cidr_am_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.is_check && !sts.empty) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.rd_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/cidr_am_dp.sv -----
// ----------------------------------------------------------------------------
// cidr_am_dp: datapath of the CIDR allowlist matcher
// Input capture, range table, one-entry-per-cycle compare and result
// registers.
// ----------------------------------------------------------------------------
module cidr_am_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cidr_am_pkg::cmd_t                     cmd,
    output cidr_am_pkg::sts_t                     sts,
    input  logic                                  s_command,
    input  logic                                  s_is_ipv6,
    input  logic [cidr_am_pkg::ADDR_W-1:0]        s_address_high,
    input  logic [cidr_am_pkg::ADDR_W-1:0]        s_address_low,
    input  logic [cidr_am_pkg::PLEN_W-1:0]        s_pfx_len,
    output logic                                  m_allowed,
    output logic [1:0]                            m_status
);

    typedef struct packed {
        logic                                 v6;
        logic [2*cidr_am_pkg::ADDR_W-1:0]     net;
        logic [cidr_am_pkg::PLEN_W-1:0]       plen;
    } entry_t;

    // Leading-ones mask for a prefix; IPv4 uses the low 32 bits only
    function automatic logic [2*cidr_am_pkg::ADDR_W-1:0] net_mask(
        input logic                           v6,
        input logic [cidr_am_pkg::PLEN_W-1:0] plen
    );
        logic [2*cidr_am_pkg::ADDR_W-1:0] m;
        for (int k = 0; k < 2 * cidr_am_pkg::ADDR_W; k++) begin
            if (v6) begin
                m[k] = ((2 * cidr_am_pkg::ADDR_W - 1 - k) < int'(plen));
            end else begin
                m[k] = (k < int'(cidr_am_pkg::V4_MAX_PLEN)) &&
                       ((int'(cidr_am_pkg::V4_MAX_PLEN) - 1 - k) < int'(plen));
            end
        end
        return m;
    endfunction

    entry_t mem [cidr_am_pkg::MAX_RANGES];

    // Held input beat
    logic                              check_reg;
    logic                              v6_reg;
    logic [2*cidr_am_pkg::ADDR_W-1:0]  addr_reg;
    logic [cidr_am_pkg::PLEN_W-1:0]    plen_reg;

    // Scan and table control
    logic [cidr_am_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [cidr_am_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                              ent_vld_reg;
    logic                              hit_reg, hit_next;
    entry_t                            ent_reg;

    // Result registers
    logic                              allowed_reg;
    logic [1:0]                        status_reg;

    logic [2*cidr_am_pkg::ADDR_W-1:0]  add_mask;
    logic [2*cidr_am_pkg::ADDR_W-1:0]  ent_mask;
    logic                              ent_match;
    logic                              plen_bad;
    logic                              full;
    logic                              do_write;
    logic [1:0]                        add_status;
    entry_t                            wr_entry;

    assign add_mask  = net_mask(v6_reg, plen_reg);
    assign ent_mask  = net_mask(ent_reg.v6, ent_reg.plen);
    assign ent_match = (ent_reg.v6 == v6_reg) &&
                       (((addr_reg ^ ent_reg.net) & ent_mask) == '0);

    assign plen_bad = v6_reg ? (plen_reg > cidr_am_pkg::V6_MAX_PLEN)
                             : (plen_reg > cidr_am_pkg::V4_MAX_PLEN);
    assign full     = (cnt_reg == cidr_am_pkg::CNT_W'(cidr_am_pkg::MAX_RANGES));

    always_comb begin
        priority if (plen_bad) begin
            add_status = cidr_am_pkg::STATUS_BAD_PLEN;
        end else if (full) begin
            add_status = cidr_am_pkg::STATUS_FULL;
        end else begin
            add_status = cidr_am_pkg::STATUS_OK;
        end
    end

    assign do_write = cmd.commit && (check_reg == cidr_am_pkg::CMD_ADD) &&
                      (add_status == cidr_am_pkg::STATUS_OK);

    assign wr_entry.v6   = v6_reg;
    assign wr_entry.net  = addr_reg & add_mask;
    assign wr_entry.plen = plen_reg;

    assign sts.is_check = (check_reg == cidr_am_pkg::CMD_CHECK);
    assign sts.empty    = (cnt_reg == '0);
    assign sts.rd_last  = (cidr_am_pkg::CNT_W'(idx_reg) ==
                           cnt_reg - cidr_am_pkg::CNT_W'(1));

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        hit_next = hit_reg;
        if (do_write) begin
            cnt_next = cnt_reg + cidr_am_pkg::CNT_W'(1);
        end
        if (cmd.load) begin
            idx_next = '0;
            hit_next = 1'b0;
        end else begin
            if (cmd.scan) begin
                idx_next = idx_reg + cidr_am_pkg::IDX_W'(1);
            end
            if (ent_vld_reg && ent_match) begin
                hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            idx_reg     <= '0;
            ent_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            ent_vld_reg <= cmd.scan;
            hit_reg     <= hit_next;
        end
    end

    // Table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[cnt_reg[cidr_am_pkg::IDX_W-1:0]] <= wr_entry;
        end
        if (cmd.scan) begin
            ent_reg <= mem[idx_reg];
        end
    end

    // Input capture; drop the upper bits of an IPv4 address
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            check_reg <= s_command;
            v6_reg    <= s_is_ipv6;
            plen_reg  <= s_pfx_len;
            if (s_is_ipv6) begin
                addr_reg <= {s_address_high, s_address_low};
            end else begin
                addr_reg <= {{(2 * cidr_am_pkg::ADDR_W - 32){1'b0}}, s_address_low[31:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (check_reg == cidr_am_pkg::CMD_CHECK) begin
                allowed_reg <= sts.empty || hit_reg;
                status_reg  <= cidr_am_pkg::STATUS_OK;
            end else begin
                allowed_reg <= 1'b0;
                status_reg  <= add_status;
            end
        end
    end

    assign m_allowed = allowed_reg;
    assign m_status  = status_reg;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CIDR allowlist matcher
// Drives add and check beats through the input channel, mirrors the range
// table to work out each verdict, and compares every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;

    import cidr_am_pkg::*;

    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int HOLD_OFF_CYCLES   = 300;
    localparam int DRAIN_CYCLES      = 40;
    // random adds stop short of the last two slots; the /0 ranges go there
    localparam int RANDOM_FILL_LIMIT = MAX_RANGES - 2;

    typedef struct packed {
        logic                command;
        logic                is_ipv6;
        logic [ADDR_W-1:0]   address_high;
        logic [ADDR_W-1:0]   address_low;
        logic [PLEN_W-1:0]   pfx_len;
    } acl_item_t;

    typedef struct packed {
        logic       allowed;
        logic [1:0] status;
    } verdict_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_command = CMD_ADD;
    logic                s_is_ipv6 = 1'b0;
    logic [ADDR_W-1:0]   s_address_high = '0;
    logic [ADDR_W-1:0]   s_address_low = '0;
    logic [PLEN_W-1:0]   s_pfx_len = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_allowed;
    logic [1:0]          m_status;

    // mirror of the range table
    int unsigned         acl_count;
    bit                  acl_v6  [MAX_RANGES];
    bit [127:0]          acl_net [MAX_RANGES];
    bit [PLEN_W-1:0]     acl_plen[MAX_RANGES];

    verdict_t            pending_verdicts[$];
    int                  mismatch_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_request;
    int                  hold_left;
    int                  quiet_cycles;

    cidr_allowlist_matcher_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_is_ipv6       (s_is_ipv6),
        .s_address_high  (s_address_high),
        .s_address_low   (s_address_low),
        .s_pfx_len       (s_pfx_len),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_allowed       (m_allowed),
        .m_status        (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Network mask in a 128-bit frame; IPv4 sits in the low 32 bits.
    function automatic bit [127:0] prefix_mask(input bit v6, input bit [PLEN_W-1:0] plen);
        bit [31:0] m4;
        if (v6) begin
            return ~128'b0 << (128 - int'(plen));
        end
        m4 = 32'hFFFF_FFFF << (32 - int'(plen));
        return {96'b0, m4};
    endfunction

    // Work out the verdict of one accepted beat and update the mirror table.
    function automatic verdict_t acl_verdict(input acl_item_t it);
        verdict_t    v;
        bit [127:0]  addr;
        bit [127:0]  m;
        int unsigned lim;
        addr = it.is_ipv6 ? {it.address_high, it.address_low}
                          : {96'b0, it.address_low[31:0]};
        v.allowed = 1'b0;
        v.status  = STATUS_OK;
        if (it.command == CMD_ADD) begin
            lim = it.is_ipv6 ? V6_MAX_PLEN : V4_MAX_PLEN;
            if (it.pfx_len > lim) begin
                v.status = STATUS_BAD_PLEN;
            end else if (acl_count >= MAX_RANGES) begin
                v.status = STATUS_FULL;
            end else begin
                m = prefix_mask(it.is_ipv6, it.pfx_len);
                acl_v6[acl_count]   = it.is_ipv6;
                acl_net[acl_count]  = addr & m;
                acl_plen[acl_count] = it.pfx_len;
                acl_count++;
            end
        end else if (acl_count == 0) begin
            v.allowed = 1'b1;
        end else begin
            for (int i = 0; i < acl_count; i++) begin
                m = prefix_mask(acl_v6[i], acl_plen[i]);
                if (acl_v6[i] == it.is_ipv6 && (addr & m) == (acl_net[i] & m)) begin
                    v.allowed = 1'b1;
                    break;
                end
            end
        end
        return v;
    endfunction

    function automatic acl_item_t make_item(input logic cmd, input logic v6,
                                            input logic [63:0] hi, input logic [63:0] lo,
                                            input logic [7:0] plen);
        acl_item_t it;
        it.command      = cmd;
        it.is_ipv6      = v6;
        it.address_high = hi;
        it.address_low  = lo;
        it.pfx_len      = plen;
        return it;
    endfunction

    // Mostly checks aimed at stored ranges (hits, and near misses one prefix
    // bit away); the rest are plain random checks and occasional adds.
    function automatic acl_item_t random_item();
        acl_item_t   it;
        bit [127:0]  addr;
        bit [127:0]  m;
        int unsigned idx;
        int unsigned lim;
        int unsigned pos;
        bit          v6;
        it = make_item(($urandom_range(7) == 0) ? CMD_ADD : CMD_CHECK, 1'($urandom_range(1)),
                       {$urandom, $urandom}, {$urandom, $urandom},
                       PLEN_W'($urandom_range(255)));
        if (it.command == CMD_ADD) begin
            lim = it.is_ipv6 ? V6_MAX_PLEN : V4_MAX_PLEN;
            if ($urandom_range(99) < 15 || acl_count >= RANDOM_FILL_LIMIT)
                it.pfx_len = PLEN_W'($urandom_range(255, lim + 1));
            else
                it.pfx_len = PLEN_W'($urandom_range(lim, 1));
        end else if (acl_count != 0 && $urandom_range(99) < 70) begin
            idx  = $urandom_range(acl_count - 1);
            v6   = acl_v6[idx];
            m    = prefix_mask(v6, acl_plen[idx]);
            addr = acl_net[idx] | ({it.address_high, it.address_low} & ~m);
            if (acl_plen[idx] != 0 && $urandom_range(99) < 30) begin
                pos = (v6 ? 128 : 32) - $urandom_range(acl_plen[idx], 1);
                addr[pos] = ~addr[pos];
            end
            it.is_ipv6 = ($urandom_range(9) == 0) ? ~v6 : v6;
            if (v6)
                {it.address_high, it.address_low} = addr;
            else
                it.address_low[31:0] = addr[31:0];
        end
        return it;
    endfunction

    // Offer one beat and hold it until accepted; idle beforehand at the
    // current sender rate, so valid is never dropped and raised in one step.
    task automatic send_item(input acl_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= it.command;
        s_is_ipv6       <= it.is_ipv6;
        s_address_high  <= it.address_high;
        s_address_low   <= it.address_low;
        s_pfx_len       <= it.pfx_len;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        pending_verdicts.insert(pending_verdicts.size(), acl_verdict(it));
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic set_idling(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Result side: check the beat taken at this edge, then pick next ready.
    always @(posedge aclk) begin
        verdict_t exp_v;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                $error("result beat with no verdict pending: allowed %0d status %0d",
                       m_allowed, m_status);
                mismatch_count++;
            end else begin
                exp_v = pending_verdicts.pop_front();
                if (m_allowed !== exp_v.allowed) begin
                    $error("allowed: expected %0d, actual %0d", exp_v.allowed, m_allowed);
                    mismatch_count++;
                end
                if (m_status !== exp_v.status) begin
                    $error("status: expected %0d, actual %0d", exp_v.status, m_status);
                    mismatch_count++;
                end
            end
        end
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Abort when neither channel has moved a beat for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_empty_table();
        send_item(make_item(CMD_CHECK, 1'b0, '0, '0, 8'd0));
        send_item(make_item(CMD_CHECK, 1'b1, '1, '1, 8'd255));
        send_item(make_item(CMD_ADD, 1'b0, '0, 64'h0000_0000_0A00_0000, 8'd33));
        send_item(make_item(CMD_ADD, 1'b1, '1, '1, 8'd129));
        send_item(make_item(CMD_ADD, 1'b1, '0, '0, 8'd255));
        send_item(make_item(CMD_CHECK, 1'b0, '1, 64'hFFFF_FFFF_1234_5678, 8'd7));
    endtask

    // Host bits set on add, junk in the IPv4 upper bits, /32, /64, /65, /127
    // and /128; then hits, misses and a version mismatch against them.
    task automatic test_directed_ranges();
        send_item(make_item(CMD_ADD, 1'b0, '1, 64'hDEAD_BEEF_0A12_3456, 8'd8));
        send_item(make_item(CMD_ADD, 1'b0, '0, 64'h0000_0000_C0A8_0101, 8'd32));
        send_item(make_item(CMD_ADD, 1'b1, '1, '1, 8'd128));
        send_item(make_item(CMD_ADD, 1'b1, 64'h2001_0DB8_0000_0001, 64'h1234_5678_9ABC_DEF0,
                            8'd64));
        send_item(make_item(CMD_ADD, 1'b1, 64'hFE80_0000_0000_0000, 64'h8000_0000_0000_0000,
                            8'd65));
        send_item(make_item(CMD_ADD, 1'b1, '0, 64'h3, 8'd127));
        send_item(make_item(CMD_CHECK, 1'b0, 64'h5555_5555_5555_5555,
                            64'hAAAA_AAAA_0AFF_FFFF, 8'd0));
        send_item(make_item(CMD_CHECK, 1'b0, '0, 64'h0B00_0000, 8'd0));
        send_item(make_item(CMD_CHECK, 1'b0, '0, 64'hC0A8_0101, 8'd0));
        send_item(make_item(CMD_CHECK, 1'b0, '0, 64'hC0A8_0100, 8'd0));
        send_item(make_item(CMD_CHECK, 1'b1, '0, 64'h0A00_0000, 8'd0));
        send_item(make_item(CMD_CHECK, 1'b1, '1, '1, 8'd0));
        send_item(make_item(CMD_CHECK, 1'b1, 64'h2001_0DB8_0000_0001, '1, 8'd0));
        send_item(make_item(CMD_CHECK, 1'b1, 64'hFE80_0000_0000_0000,
                            64'h7FFF_FFFF_FFFF_FFFF, 8'd0));
        send_item(make_item(CMD_CHECK, 1'b1, 64'hFE80_0000_0000_0000, '1, 8'd0));
        send_item(make_item(CMD_CHECK, 1'b1, '0, 64'h2, 8'd0));
    endtask

    // Stall the result side long enough to fill the block and hold its input,
    // keep offering beats meanwhile, then pause until all verdicts are back.
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_request = HOLD_OFF_CYCLES;
        repeat (12) send_item(random_item());
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        set_idling(idle_pct, stall_pct);
        repeat (n_items) send_item(random_item());
    endtask

    // Fill the remaining slots, the last two with /0 ranges, then hit the
    // full table and check that an invalid prefix wins over table full.
    task automatic test_full_table();
        logic v6;
        set_idling(10, 10);
        while (acl_count < RANDOM_FILL_LIMIT) begin
            v6 = 1'($urandom_range(1));
            send_item(make_item(CMD_ADD, v6, {$urandom, $urandom}, {$urandom, $urandom},
                                PLEN_W'($urandom_range(v6 ? V6_MAX_PLEN : V4_MAX_PLEN,
                                                       1))));
        end
        send_item(make_item(CMD_ADD, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 8'd0));
        send_item(make_item(CMD_CHECK, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 8'd0));
        send_item(make_item(CMD_CHECK, 1'b0, '0, {$urandom, $urandom}, 8'd0));
        send_item(make_item(CMD_ADD, 1'b0, '1, '1, 8'd0));
        send_item(make_item(CMD_ADD, 1'b1, '0, '0, 8'd0));
        send_item(make_item(CMD_ADD, 1'b1, '0, '0, 8'd200));
        send_item(make_item(CMD_ADD, 1'b0, '0, '0, 8'd33));
        send_item(make_item(CMD_ADD, 1'b0, '0, 64'hC0A8_0001, 8'd32));
        send_item(make_item(CMD_CHECK, 1'b0, '0, {$urandom, $urandom}, 8'd0));
        repeat (30) send_item(random_item());
    endtask

    initial begin
        acl_count      = 0;
        mismatch_count = 0;
        hold_request   = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        set_idling(0, 0);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_directed_ranges();
        test_random_traffic(210, 0, 0);
        test_backpressure();
        test_random_traffic(210, 64, 0);
        test_random_traffic(210, 0, 64);
        test_random_traffic(210, 10, 10);
        test_full_table();

        stop_sending();
        set_idling(0, 0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
